FILE: sv/acd_pkg.sv
// ----------------------------------------------------------------------------
// acd_pkg
// Shared types, register indexes and AES round functions for the CBC decryptor.
// ----------------------------------------------------------------------------
package acd_pkg;

    localparam int unsigned BLK_W   = 128;
    localparam int unsigned NROUNDS = 10;
    localparam int unsigned IDX_W   = 8;

    typedef logic [BLK_W-1:0] blk_t;
    typedef logic [NROUNDS:0][BLK_W-1:0] rk_arr_t;

    localparam logic [IDX_W-1:0] REG_KEY_HIGH = 8'd0;
    localparam logic [IDX_W-1:0] REG_KEY_LOW  = 8'd1;
    localparam logic [IDX_W-1:0] REG_IV_HIGH  = 8'd2;
    localparam logic [IDX_W-1:0] REG_IV_LOW   = 8'd3;

    localparam logic [7:0] RCON [NROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    localparam logic [7:0] INV_SBOX [256] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte i of the block sits at bits [127-8i -: 8]
    function automatic blk_t inv_shift_sub(input blk_t s);
        blk_t t;
        int   src;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = r + 4 * ((c - r + 4) % 4);
                t[BLK_W-1-8*(r+4*c) -: 8] = INV_SBOX[s[BLK_W-1-8*src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic blk_t inv_mix(input blk_t s);
        blk_t       t;
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] m11 [4];
        logic [7:0] m13 [4];
        logic [7:0] m14 [4];
        for (int c = 0; c < 4; c++) begin
            for (int k = 0; k < 4; k++) begin
                a[k]   = s[BLK_W-1-8*(4*c+k) -: 8];
                x2[k]  = xtime(a[k]);
                x4[k]  = xtime(x2[k]);
                x8[k]  = xtime(x4[k]);
                m9[k]  = x8[k] ^ a[k];
                m11[k] = x8[k] ^ x2[k] ^ a[k];
                m13[k] = x8[k] ^ x4[k] ^ a[k];
                m14[k] = x8[k] ^ x4[k] ^ x2[k];
            end
            t[BLK_W-1-8*(4*c)   -: 8] = m14[0] ^ m11[1] ^ m13[2] ^ m9[3];
            t[BLK_W-1-8*(4*c+1) -: 8] = m9[0]  ^ m14[1] ^ m11[2] ^ m13[3];
            t[BLK_W-1-8*(4*c+2) -: 8] = m13[0] ^ m9[1]  ^ m14[2] ^ m11[3];
            t[BLK_W-1-8*(4*c+3) -: 8] = m11[0] ^ m13[1] ^ m9[2]  ^ m14[3];
        end
        return t;
    endfunction

endpackage

FILE: sv/acd_keyexp.sv
// ----------------------------------------------------------------------------
// acd_keyexp
// Round key expander: one round key per cycle after reset or a key write.
// ----------------------------------------------------------------------------
module acd_keyexp
    import acd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  blk_t    key,
    output logic    busy,
    output rk_arr_t round_keys
);

    logic       busy_reg, busy_next;
    logic [3:0] cnt_reg, cnt_next;
    blk_t       cur_reg;
    blk_t       rk_reg [NROUNDS+1];
    blk_t       step_key;
    logic [31:0] rot, sub;

    always_comb
    begin
        rot = {cur_reg[23:0], cur_reg[31:24]};
        sub = {SBOX[rot[31:24]], SBOX[rot[23:16]], SBOX[rot[15:8]], SBOX[rot[7:0]]};
        sub = sub ^ {RCON[cnt_reg - 4'd1], 24'd0};
        step_key[127:96] = cur_reg[127:96] ^ sub;
        step_key[95:64]  = cur_reg[95:64]  ^ step_key[127:96];
        step_key[63:32]  = cur_reg[63:32]  ^ step_key[95:64];
        step_key[31:0]   = cur_reg[31:0]   ^ step_key[63:32];
    end

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 4'd0;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 4'd1;
            if (cnt_reg == 4'(NROUNDS))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg && !start)
        begin
            if (cnt_reg == 4'd0)
            begin
                rk_reg[0] <= key;
                cur_reg   <= key;
            end
            else
            begin
                rk_reg[cnt_reg] <= step_key;
                cur_reg         <= step_key;
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i <= NROUNDS; i++)
            round_keys[i] = rk_reg[i];
    end

    assign busy = busy_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= 4'(NROUNDS))
        else $error("key expansion counter out of range");
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg && cnt_reg == 4'd0)
        else $error("key write did not restart expansion");
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && !start && cnt_reg == 4'(NROUNDS) |=> !busy_reg)
        else $error("expansion did not finish");

endmodule

FILE: sv/acd_cell.sv
// ----------------------------------------------------------------------------
// acd_cell
// One inverse round stage: shift/sub, add round key, inverse mix columns.
// ----------------------------------------------------------------------------
module acd_cell
    import acd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic in_vld,
    input  blk_t in_state,
    input  blk_t in_chain,
    input  blk_t round_key,
    output logic out_vld,
    output blk_t out_state,
    output blk_t out_chain
);

    logic vld_reg;
    blk_t state_reg, state_next;
    blk_t chain_reg;

    assign state_next = inv_mix(inv_shift_sub(in_state) ^ round_key);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (en)
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
            chain_reg <= in_chain;
        end
    end

    assign out_vld   = vld_reg;
    assign out_state = state_reg;
    assign out_chain = chain_reg;

endmodule

FILE: sv/aes128_cbc_decryptor_unit.sv
// ----------------------------------------------------------------------------
// aes128_cbc_decryptor_unit
// AES-128 CBC decryption as a chain of inverse round cells.
// ----------------------------------------------------------------------------
// Datapath: input stage, nine round cells, final round into the output
//   register.
// Throughput: one block per cycle outside key expansion; the round chain
//   stalls only when the output beat is held.
// Reset: key, IV and chaining value clear to zero; the key schedule is then
//   rebuilt, as after every key write, with in_ready low.
module aes128_cbc_decryptor_unit
    import acd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [63:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [63:0]      cipher_high,
    input  logic [63:0]      cipher_low,
    input  logic             restart,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [63:0]      plain_high,
    output logic [63:0]      plain_low
);

    localparam int unsigned NCELLS = NROUNDS - 1;

    logic [63:0] key_high_reg, key_low_reg, iv_high_reg, iv_low_reg;
    blk_t        last_reg;
    logic        key_write, kbusy, advance, accept;
    rk_arr_t     round_keys;

    logic        v0_reg;
    blk_t        s0_reg, c0_reg;
    logic        cell_vld   [NCELLS+1];
    blk_t        cell_state [NCELLS+1];
    blk_t        cell_chain [NCELLS+1];
    logic        out_vld_reg;
    blk_t        out_reg, out_next;

    assign key_write = cfg_we && (cfg_index == REG_KEY_HIGH || cfg_index == REG_KEY_LOW);
    assign advance   = !out_vld_reg || out_ready;
    assign in_ready  = advance && !kbusy;
    assign accept    = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= '0;
            key_low_reg  <= '0;
            iv_high_reg  <= '0;
            iv_low_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_HIGH: key_high_reg <= cfg_data;
                REG_KEY_LOW:  key_low_reg  <= cfg_data;
                REG_IV_HIGH:  iv_high_reg  <= cfg_data;
                REG_IV_LOW:   iv_low_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    acd_keyexp u_keyexp (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (key_write),
        .key        ({key_high_reg, key_low_reg}),
        .busy       (kbusy),
        .round_keys (round_keys)
    );

    // Chaining value follows the previous ciphertext beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg <= '0;
            v0_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
                last_reg <= {cipher_high, cipher_low};
            if (advance)
                v0_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s0_reg <= {cipher_high, cipher_low} ^ round_keys[NROUNDS];
            c0_reg <= restart ? {iv_high_reg, iv_low_reg} : last_reg;
        end
    end

    assign cell_vld[0]   = v0_reg;
    assign cell_state[0] = s0_reg;
    assign cell_chain[0] = c0_reg;

    for (genvar k = 1; k <= NCELLS; k++)
    begin : g_cell
        acd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_vld    (cell_vld[k-1]),
            .in_state  (cell_state[k-1]),
            .in_chain  (cell_chain[k-1]),
            .round_key (round_keys[NROUNDS-k]),
            .out_vld   (cell_vld[k]),
            .out_state (cell_state[k]),
            .out_chain (cell_chain[k])
        );
    end

    assign out_next = inv_shift_sub(cell_state[NCELLS]) ^ round_keys[0] ^ cell_chain[NCELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (advance)
            out_vld_reg <= cell_vld[NCELLS];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= out_next;
    end

    assign out_valid  = out_vld_reg;
    assign plain_high = out_reg[127:64];
    assign plain_low  = out_reg[63:0];

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> !kbusy)
        else $error("beat accepted during key expansion");
    a_key_write_block: assert property (@(posedge clk) disable iff (!rst_n)
        key_write |=> !in_ready)
        else $error("input open right after key write");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v0_reg) && $stable(cell_vld[NCELLS]))
        else $error("pipeline moved while output stalled");
    a_chain_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> last_reg == $past({cipher_high, cipher_low}))
        else $error("chaining value not updated");

endmodule
